// ===== design/shp_pkg.sv =====
// Shared types and constants for the shortest Hamiltonian path search unit.
package shp_pkg;
  localparam int unsigned MaxCitiesDef = 8;
  localparam int unsigned WeightBitsDef = 16;
  localparam int unsigned DistBits = 20;
  localparam logic [DistBits-1:0] DistMax = '1;
  localparam int unsigned CfgBits = 4;
  localparam int unsigned CityOutBits = 3;

  typedef enum logic [3:0] {
    ST_LOAD, ST_INIT, ST_COST, ST_SCAN, ST_CEIL, ST_SWAP, ST_REV, ST_EMIT
  } shp_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // write weight at load count
    logic init;      // ascending order, start cost walk
    logic cost_step; // one edge of the cost walk
    logic scan_step; // one step of the pivot search
    logic ceil_step; // one step of the ceiling search
    logic swap;      // swap pivot and ceiling
    logic rev_step;  // one swap of the suffix reversal
    logic emit;      // present one city
  } shp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic load_done;
    logic cost_done;
    logic scan_done;
    logic no_pivot;
    logic ceil_done;
    logic rev_done;
    logic emit_done;
  } shp_sts_t;
endpackage

// ===== design/shp_ctrl.sv =====
// Controller state machine for the path search.
module shp_ctrl import shp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  shp_sts_t sts_i,
  output shp_cmd_t cmd_o,
  output logic     busy_o
);
  shp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_LOAD;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    busy_o = 1'b1;
    unique case (state_q)
      ST_LOAD: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.load_done) state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd_o.init = 1'b1;
        state_d = ST_COST;
      end
      ST_COST: begin
        cmd_o.cost_step = 1'b1;
        if (sts_i.cost_done) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.no_pivot) state_d = ST_EMIT;
        else if (sts_i.scan_done) state_d = ST_CEIL;
      end
      ST_CEIL: begin
        cmd_o.ceil_step = 1'b1;
        if (sts_i.ceil_done) state_d = ST_SWAP;
      end
      ST_SWAP: begin
        cmd_o.swap = 1'b1;
        state_d = ST_REV;
      end
      ST_REV: begin
        cmd_o.rev_step = 1'b1;
        if (sts_i.rev_done) state_d = ST_COST;
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        if (sts_i.emit_done) state_d = ST_LOAD;
      end
      default: state_d = ST_LOAD;
    endcase
  end
endmodule

// ===== design/shp_datapath.sv =====
// Weight memory, order registers, cost walk and permutation stepping.
module shp_datapath import shp_pkg::*; #(
  parameter int unsigned MaxCities = MaxCitiesDef,
  parameter int unsigned WeightBits = WeightBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  shp_cmd_t               cmd_i,
  input  logic [WeightBits-1:0]  edge_weight_i,
  input  logic [CfgBits-1:0]     num_cities_i,
  output shp_sts_t               sts_o,
  output logic                   result_valid_o,
  output logic [CityOutBits-1:0] city_index_o,
  output logic [DistBits-1:0]    total_distance_o,
  output logic                   last_city_o
);
  localparam int unsigned Depth = MaxCities * MaxCities;
  localparam int unsigned AddrBits = $clog2(Depth);
  localparam int unsigned CntBits = $clog2(Depth + 1);
  localparam int unsigned CityBits = $clog2(MaxCities);
  localparam int unsigned OrdLen = MaxCities - 1;
  localparam int unsigned NBits = $clog2(MaxCities + 1);

  logic [WeightBits-1:0] mem_q [Depth];
  logic [WeightBits-1:0] rd_q;
  logic [CntBits-1:0] cnt_q;
  logic [CityBits-1:0] ord_q [OrdLen];
  logic [CityBits-1:0] best_q [OrdLen];
  logic [DistBits-1:0] best_dist_q, acc_q;
  logic first_q, prune_q;
  // k_q: edges done / ceil index / rev low index / emit index; piv_q: scan index
  logic [NBits-1:0] k_q, hi_q, piv_q, ceil_q;
  logic [NBits-1:0] n;
  logic [NBits-1:0] m; // number of permuted cities
  logic [AddrBits-1:0] raddr;

  always_comb begin
    if (num_cities_i < 4'd2) n = NBits'(2);
    else if (num_cities_i > CfgBits'(MaxCities)) n = NBits'(MaxCities);
    else n = NBits'(num_cities_i);
    m = n - NBits'(1);
  end

  // Cost walk: k_q = number of edges read so far; address for edge k_q.
  logic [CityBits-1:0] from_c, to_c;
  always_comb begin
    from_c = (k_q == '0) ? '0 : ord_q[k_q[CityBits-1:0] - CityBits'(1)];
    to_c = (k_q < NBits'(OrdLen)) ? ord_q[k_q[CityBits-1:0]] : '0;
    raddr = AddrBits'(n) * AddrBits'(from_c) + AddrBits'(to_c);
  end

  // Read one step ahead: rd_q holds edge k_q-1 while in cost walk.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) mem_q[cnt_q[AddrBits-1:0]] <= edge_weight_i;
    rd_q <= mem_q[raddr];
  end

  logic [DistBits:0] sum;
  logic [DistBits-1:0] sat;
  assign sum = {1'b0, acc_q} + (DistBits+1)'(rd_q);
  assign sat = sum[DistBits] ? DistMax : sum[DistBits-1:0];

  assign sts_o.load_done = (cnt_q + CntBits'(1)) >= CntBits'(n) * CntBits'(n);
  assign sts_o.cost_done = prune_q || (k_q == m) || (!first_q && k_q != '0 && sat >= best_dist_q);
  assign sts_o.scan_done = (piv_q == '0) || (ord_q[piv_q[CityBits-1:0] - CityBits'(1)] <
                           ord_q[piv_q[CityBits-1:0]]);
  assign sts_o.no_pivot = (piv_q == '0);
  assign sts_o.ceil_done = (k_q >= m);
  assign sts_o.rev_done = (k_q >= hi_q) || (k_q + NBits'(1) >= hi_q);
  assign sts_o.emit_done = (k_q == m);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      k_q <= '0;
      first_q <= 1'b1;
      prune_q <= 1'b0;
      best_dist_q <= DistMax;
      result_valid_o <= 1'b0;
      for (int i = 0; i < int'(OrdLen); i++) ord_q[i] <= CityBits'(i + 1);
    end else begin
      result_valid_o <= 1'b0;
      if (cmd_i.load) cnt_q <= sts_o.load_done ? '0 : cnt_q + CntBits'(1);
      if (cmd_i.init) begin
        for (int i = 0; i < int'(OrdLen); i++) ord_q[i] <= CityBits'(i + 1);
        first_q <= 1'b1;
        best_dist_q <= DistMax;
        k_q <= '0;
        acc_q <= '0;
        prune_q <= 1'b0;
      end
      if (cmd_i.cost_step) begin
        if (k_q != '0) acc_q <= sat;
        if (sts_o.cost_done) begin
          if (!prune_q && k_q == m && (first_q || sat < best_dist_q)) begin
            best_dist_q <= sat;
            best_q <= ord_q;
          end
          first_q <= 1'b0;
          piv_q <= m - NBits'(1);
          prune_q <= 1'b0;
        end else begin
          k_q <= k_q + NBits'(1);
          if (!first_q && k_q != '0 && sat >= best_dist_q) prune_q <= 1'b1;
        end
      end
      if (cmd_i.scan_step) begin
        if (sts_o.no_pivot) k_q <= '0;
        else if (sts_o.scan_done) begin
          piv_q <= piv_q - NBits'(1);
          ceil_q <= piv_q;
          k_q <= piv_q + NBits'(1);
        end else piv_q <= piv_q - NBits'(1);
      end
      if (cmd_i.ceil_step && !sts_o.ceil_done) begin
        if (ord_q[k_q[CityBits-1:0]] > ord_q[piv_q[CityBits-1:0]] &&
            ord_q[k_q[CityBits-1:0]] < ord_q[ceil_q[CityBits-1:0]])
          ceil_q <= k_q;
        k_q <= k_q + NBits'(1);
      end
      if (cmd_i.swap) begin
        ord_q[piv_q[CityBits-1:0]] <= ord_q[ceil_q[CityBits-1:0]];
        ord_q[ceil_q[CityBits-1:0]] <= ord_q[piv_q[CityBits-1:0]];
        k_q <= piv_q + NBits'(1);
        hi_q <= m - NBits'(1);
      end
      if (cmd_i.rev_step) begin
        if (k_q < hi_q) begin
          ord_q[k_q[CityBits-1:0]] <= ord_q[hi_q[CityBits-1:0]];
          ord_q[hi_q[CityBits-1:0]] <= ord_q[k_q[CityBits-1:0]];
        end
        hi_q <= hi_q - NBits'(1);
        if (sts_o.rev_done) begin
          k_q <= '0;
          acc_q <= '0;
        end else begin
          k_q <= k_q + NBits'(1);
        end
      end
      if (cmd_i.emit) begin
        result_valid_o <= 1'b1;
        city_index_o <= (k_q == '0) ? '0 :
                        CityOutBits'(best_q[k_q[CityBits-1:0] - CityBits'(1)]);
        total_distance_o <= best_dist_q;
        last_city_o <= (k_q == m);
        k_q <= sts_o.emit_done ? '0 : k_q + NBits'(1);
        if (sts_o.emit_done)
          for (int i = 0; i < int'(OrdLen); i++) ord_q[i] <= CityBits'(i + 1);
      end
    end
  end
endmodule

// ===== design/shortest_hamiltonian_path_search_unit.sv =====
// Top level of the shortest Hamiltonian path search unit.
// Usage:
//  - Set cfg_data_i with cfg_valid/cfg_ready (always ready) to the city
//    count n (2..MaxCities, clamped) while the unit is idle.
//  - Feed n*n edge weights row by row: an item is taken when start is high
//    and busy low, one weight per cycle.
//  - After the last weight busy rises and the exhaustive search runs over
//    all (n-1)! orders; each order is a cost walk through the single
//    weight memory read port followed by permutation stepping. Pruned
//    orders stop the walk early.
//  - Then n results come on consecutive cycles, each marked by result_valid_o
//    for one cycle, city 0 first, last_city_o on the final one. The
//    receiver cannot stall; results are simply presented.
//  - busy drops with the last result and loading of the next matrix may
//    start.
//  - Reset clears load count and controller; weight memory is not cleared.
module shortest_hamiltonian_path_search_unit import shp_pkg::*; #(
  parameter int unsigned MaxCities = MaxCitiesDef,
  parameter int unsigned WeightBits = WeightBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [WeightBits-1:0]  edge_weight_i,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CfgBits-1:0]     cfg_data_i,
  output logic                   result_valid_o,
  output logic [CityOutBits-1:0] city_index_o,
  output logic [DistBits-1:0]    total_distance_o,
  output logic                   last_city_o
);
  shp_cmd_t cmd;
  shp_sts_t sts;
  logic [CfgBits-1:0] num_cities_q;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) num_cities_q <= CfgBits'(8);
    else if (cfg_valid) num_cities_q <= cfg_data_i;
  end

  shp_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .sts_i(sts), .cmd_o(cmd), .busy_o(busy)
  );

  shp_datapath #(.MaxCities(MaxCities), .WeightBits(WeightBits)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .edge_weight_i, .num_cities_i(num_cities_q),
    .sts_o(sts), .result_valid_o, .city_index_o, .total_distance_o, .last_city_o
  );
endmodule

// ===== design/shp_checker.sv =====
// Port-level checker for the path search unit, bound to the top level.
module shp_checker import shp_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic busy,
  input logic result_valid_o,
  input logic last_city_o,
  input logic [CityOutBits-1:0] city_index_o
);
  // results before the last city only while busy
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_city_o) |-> busy) else $error("result while idle");
  // first city of a path is city 0
  a_first_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !$past(result_valid_o)) |-> city_index_o == '0)
    else $error("path does not start at city 0");
  // results run back to back until the last
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_city_o) |=> result_valid_o)
    else $error("gap in result burst");
  // idle follows the last city
  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_city_o) |=> !busy) else $error("busy after last");
endmodule

bind shortest_hamiltonian_path_search_unit shp_checker u_chk (
  .clk_i, .rst_ni, .busy, .result_valid_o, .last_city_o, .city_index_o
);

// ===== dv/tb.sv =====
// Testbench for the shortest Hamiltonian path search unit: queued weight driver, result checker.
module tb;
  import shp_pkg::*;

  typedef struct {
    logic [CityOutBits-1:0] city;
    logic [DistBits-1:0]    distance;
    logic                   last;
  } path_city_t;

  localparam int unsigned CycleLimit = 1500000;
  localparam int unsigned SettleCycles = 20;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [WeightBitsDef-1:0] edge_weight_i = '0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CfgBits-1:0]     cfg_data_i = '0;
  logic                   result_valid_o;
  logic [CityOutBits-1:0] city_index_o;
  logic [DistBits-1:0]    total_distance_o;
  logic                   last_city_o;

  logic [WeightBitsDef-1:0] weight_q[$];
  path_city_t               path_q[$];
  logic [WeightBitsDef-1:0] weight_mem[MaxCitiesDef*MaxCitiesDef];
  int unsigned              weights_loaded = 0;
  logic [CfgBits-1:0]       cities_reg = CfgBits'(MaxCitiesDef);
  int unsigned              sender_idle_pct = 0;
  int unsigned              cycle_count = 0;
  bit                       failed = 1'b0;

  shortest_hamiltonian_path_search_unit u_top (
    .clk_i, .rst_ni, .start, .busy, .edge_weight_i, .cfg_valid, .cfg_ready,
    .cfg_data_i, .result_valid_o, .city_index_o, .total_distance_o, .last_city_o
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned cities_in_force();
    if (cities_reg < 2) return 2;
    if (cities_reg > MaxCitiesDef) return MaxCitiesDef;
    return cities_reg;
  endfunction

  function automatic int unsigned dist_add(int unsigned a, int unsigned b);
    return (a + b > DistMax) ? DistMax : a + b;
  endfunction

  // Cost of 0 -> ord[0] -> ... -> ord[n-2]; 0 when pruned at bound.
  function automatic bit walk_cost(int unsigned n, int ord[MaxCitiesDef-1],
                                   bit bounded, int unsigned bound,
                                   output int unsigned cost);
    int unsigned d;
    d = weight_mem[ord[0]];
    if (bounded && d >= bound) return 0;
    for (int i = 0; i + 2 < n; i++) begin
      d = dist_add(d, weight_mem[n * ord[i] + ord[i+1]]);
      if (bounded && d >= bound) return 0;
    end
    cost = d;
    return 1;
  endfunction

  function automatic void search_shortest_path(int unsigned n);
    int ord[MaxCitiesDef-1];
    int best[MaxCitiesDef-1];
    int unsigned best_dist, cost;
    int i, k, ceil_at, lo, hi, t, m;
    path_city_t pc;
    m = n - 1;
    for (i = 0; i < MaxCitiesDef - 1; i++) ord[i] = i + 1;
    void'(walk_cost(n, ord, 0, 0, best_dist));
    best = ord;
    forever begin
      for (i = m - 2; i >= 0; i--) if (ord[i] < ord[i+1]) break;
      if (i < 0) break;
      ceil_at = i + 1;
      for (k = i + 2; k < m; k++)
        if (ord[k] > ord[i] && ord[k] < ord[ceil_at]) ceil_at = k;
      t = ord[i]; ord[i] = ord[ceil_at]; ord[ceil_at] = t;
      lo = i + 1;
      hi = m - 1;
      while (lo < hi) begin
        t = ord[lo]; ord[lo] = ord[hi]; ord[hi] = t;
        lo++;
        hi--;
      end
      if (walk_cost(n, ord, 1, best_dist, cost)) begin
        best_dist = cost;
        best = ord;
      end
    end
    for (k = 0; k < n; k++) begin
      pc.city = (k == 0) ? '0 : CityOutBits'(best[k-1]);
      pc.distance = DistBits'(best_dist);
      pc.last = (k + 1 == n);
      path_q.push_back(pc);
    end
  endfunction

  function automatic void load_weight(logic [WeightBitsDef-1:0] w);
    int unsigned n;
    n = cities_in_force();
    if (weights_loaded < MaxCitiesDef * MaxCitiesDef) weight_mem[weights_loaded] = w;
    weights_loaded++;
    if (weights_loaded >= n * n) begin
      search_shortest_path(n);
      weights_loaded = 0;
    end
  endfunction

  // Driver: one item per accepted start, random gaps.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) load_weight(edge_weight_i);
      if (!(start && busy)) begin
        if (weight_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          start <= 1'b1;
          edge_weight_i <= weight_q.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    path_city_t exp_pc;
    if (rst_ni && result_valid_o) begin
      if (path_q.size() == 0) begin
        $error("unexpected result: city %0d distance %0d", city_index_o, total_distance_o);
        failed = 1'b1;
      end else begin
        exp_pc = path_q.pop_front();
        if (city_index_o !== exp_pc.city) begin
          $error("city_index: expected %0d, got %0d", exp_pc.city, city_index_o);
          failed = 1'b1;
        end
        if (total_distance_o !== exp_pc.distance) begin
          $error("total_distance: expected %0d, got %0d", exp_pc.distance,
                 total_distance_o);
          failed = 1'b1;
        end
        if (last_city_o !== exp_pc.last) begin
          $error("last_city: expected %0d, got %0d", exp_pc.last, last_city_o);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("shortest_hamiltonian_path_search_unit: mismatch");
      $finish;
    end
  end

  task automatic wait_quiet();
    do @(posedge clk_i);
    while (weight_q.size() != 0 || start || path_q.size() != 0 || busy);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Waits only for the sender to drain; used for the mid-load register change.
  task automatic wait_sent();
    do @(posedge clk_i);
    while (weight_q.size() != 0 || start);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_cities(logic [CfgBits-1:0] v);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i);
    while (!cfg_ready);
    cities_reg = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [WeightBitsDef-1:0] rand_weight();
    case ($urandom_range(9))
      0: return '1;
      1: return '0;
      2, 3: return WeightBitsDef'($urandom_range(15));
      default: return WeightBitsDef'($urandom_range(65535));
    endcase
  endfunction

  initial begin
    int unsigned n;
    int plan_cfg[7];
    int plan_mats[7];
    int plan_idle[7];
    plan_cfg = '{3, 4, 5, 0, 7, 15, 6};
    plan_mats = '{1, 1, 1, 2, 1, 1, 1};
    plan_idle = '{0, 70, 14, 0, 14, 0, 70};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // two cities: saturated weights, then all-zero weights
    write_cities(2);
    repeat (4) weight_q.push_back('1);
    repeat (4) weight_q.push_back('0);
    wait_quiet();
    // three cities, extremes mixed so the later order wins
    write_cities(3);
    weight_q.push_back('0); weight_q.push_back('1); weight_q.push_back(16'h0001);
    weight_q.push_back('1); weight_q.push_back('0); weight_q.push_back(16'h8000);
    weight_q.push_back('0); weight_q.push_back(16'h7fff); weight_q.push_back('0);
    wait_quiet();
    // register drops from three to below range while part loaded
    repeat (3) weight_q.push_back(rand_weight());
    wait_sent();
    write_cities(1);
    weight_q.push_back(rand_weight());
    wait_quiet();

    foreach (plan_cfg[p]) begin
      write_cities(CfgBits'(plan_cfg[p]));
      sender_idle_pct = plan_idle[p];
      n = cities_in_force();
      repeat (plan_mats[p] * n * n) weight_q.push_back(rand_weight());
      wait_quiet();
    end

    if (!failed && path_q.size() == 0) begin
      $display("shortest_hamiltonian_path_search_unit: match");
    end else begin
      $display("shortest_hamiltonian_path_search_unit: mismatch");
    end
    $finish;
  end
endmodule
